// ===== src/rbu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbu_pkg
// Shared types and constants of the run-length bitmap unpacker.
// ----------------------------------------------------------------------------
package rbu_pkg;

	localparam int unsigned OFFSET_BITS_DEF = 24;
	localparam int unsigned DEST_OFFSET_W   = 24;
	localparam int unsigned FILL_LENGTH_W   = 15;
	localparam int unsigned CMD_FIFO_DEPTH  = 4;

	// Short opcodes
	localparam logic [7:0]  OP_RUN       = 8'h00;
	localparam logic [7:0]  OP_LONG      = 8'h80;
	localparam logic [7:0]  OP_SKIP_MASK = 8'h7f;

	// Long code classes
	localparam logic [15:0] LONG_END      = 16'h0000;
	localparam logic [15:0] LONG_COPY_MIN = 16'h8000;
	localparam logic [15:0] LONG_RUN_MIN  = 16'hC000;
	localparam logic [15:0] LONG_COPY_MSK = 16'h7fff;
	localparam logic [15:0] LONG_RUN_MSK  = 16'h3fff;

	typedef struct packed {
		logic [7:0] src_byte;
		logic       image_start;
	} rbu_in_t;

	typedef struct packed {
		logic [7:0]               fill_value;
		logic [FILL_LENGTH_W-1:0] fill_length;
		logic [DEST_OFFSET_W-1:0] dest_offset;
		logic                     image_done;
	} rbu_out_t;

	// Write command from the parser to the offset stage
	typedef struct packed {
		logic [7:0]               value;
		logic [FILL_LENGTH_W-1:0] length;
		logic                     done;
		logic                     restart;  // offset restarts at zero first
	} rbu_cmd_t;

endpackage

// ===== src/rbu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbu_front
// Byte parser: walks the opcode stream and turns it into write commands.
// ----------------------------------------------------------------------------
module rbu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  rbu_pkg::rbu_in_t in_item,
	output logic             cmd_push,
	output rbu_pkg::rbu_cmd_t cmd
);
	import rbu_pkg::*;

	typedef enum logic [7:0] {
		PH_OPCODE     = 8'b0000_0001,
		PH_RUN_COUNT  = 8'b0000_0010,
		PH_RUN_VALUE  = 8'b0000_0100,
		PH_COPY       = 8'b0000_1000,
		PH_LONG_LO    = 8'b0001_0000,
		PH_LONG_HI    = 8'b0010_0000,
		PH_LONG_VALUE = 8'b0100_0000,
		PH_DONE       = 8'b1000_0000
	} rbu_phase_t;

	rbu_phase_t               phase_q, phase, phase_d;
	logic [FILL_LENGTH_W-1:0] pending_q, pend, pending_d;
	logic [7:0]               long_lo_q, lo, long_lo_d;
	logic                     restart_pend_q;
	logic [7:0]               b;
	logic [15:0]              code;
	logic                     emit;
	logic [7:0]               e_value;
	logic [FILL_LENGTH_W-1:0] e_length;
	logic                     e_done;

	assign b    = in_item.src_byte;
	assign code = {b, lo};

	always_comb begin
		// a new image restarts the parser before the byte is looked at
		phase     = in_item.image_start ? PH_OPCODE : phase_q;
		pend      = in_item.image_start ? '0 : pending_q;
		lo        = in_item.image_start ? 8'h00 : long_lo_q;
		phase_d   = phase;
		pending_d = pend;
		long_lo_d = lo;
		emit      = 1'b0;
		e_value   = 8'h00;
		e_length  = '0;
		e_done    = 1'b0;
		unique case (phase)
			PH_OPCODE: begin
				if (b == OP_RUN) begin
					phase_d = PH_RUN_COUNT;
				end else if (b < OP_LONG) begin
					pending_d = FILL_LENGTH_W'(b);
					phase_d   = PH_COPY;
				end else if (b > OP_LONG) begin
					emit     = 1'b1;
					e_length = FILL_LENGTH_W'(b & OP_SKIP_MASK);
				end else begin
					phase_d = PH_LONG_LO;
				end
			end
			PH_RUN_COUNT: begin
				pending_d = FILL_LENGTH_W'(b);
				phase_d   = PH_RUN_VALUE;
			end
			PH_RUN_VALUE, PH_LONG_VALUE: begin
				phase_d  = PH_OPCODE;
				emit     = (pend != '0);
				e_value  = b;
				e_length = pend;
			end
			PH_COPY: begin
				pending_d = (pend != '0) ? pend - FILL_LENGTH_W'(1) : pend;
				if (pending_d == '0) begin
					phase_d = PH_OPCODE;
				end
				emit     = 1'b1;
				e_value  = b;
				e_length = FILL_LENGTH_W'(1);
			end
			PH_LONG_LO: begin
				long_lo_d = b;
				phase_d   = PH_LONG_HI;
			end
			PH_LONG_HI: begin
				phase_d = PH_OPCODE;
				if (code == LONG_END) begin
					phase_d = PH_DONE;
					emit    = 1'b1;
					e_done  = 1'b1;
				end else if (code < LONG_COPY_MIN) begin
					emit     = 1'b1;
					e_length = FILL_LENGTH_W'(code);
				end else if (code < LONG_RUN_MIN) begin
					pending_d = FILL_LENGTH_W'(code & LONG_COPY_MSK);
					if (pending_d != '0) begin
						phase_d = PH_COPY;
					end
				end else begin
					pending_d = FILL_LENGTH_W'(code & LONG_RUN_MSK);
					phase_d   = PH_LONG_VALUE;
				end
			end
			default: ;  // image ended: bytes dropped until the next start
		endcase
	end

	assign cmd_push    = accept && emit;
	assign cmd.value   = e_value;
	assign cmd.length  = e_length;
	assign cmd.done    = e_done;
	assign cmd.restart = in_item.image_start || restart_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_OPCODE;
			pending_q      <= '0;
			long_lo_q      <= 8'h00;
			restart_pend_q <= 1'b0;
		end else if (accept) begin
			phase_q        <= phase_d;
			pending_q      <= pending_d;
			long_lo_q      <= long_lo_d;
			// an image start that emits nothing hands the restart on
			restart_pend_q <= emit ? 1'b0 : cmd.restart;
		end
	end

	a_done_parks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && cmd.done |=> phase_q == PH_DONE)
		else $error("parser not parked after end of image");

	a_copy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_COPY |-> pending_q != '0)
		else $error("copy phase with no literals left");

endmodule

// ===== src/rbu_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbu_cmd_fifo
// Short command queue between the parser and the offset stage.
// ----------------------------------------------------------------------------
module rbu_cmd_fifo #(
	parameter int unsigned DEPTH = rbu_pkg::CMD_FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rbu_pkg::rbu_cmd_t wr_cmd,
	output logic              full,
	input  logic              pop,
	output rbu_pkg::rbu_cmd_t rd_cmd,
	output logic              empty
);
	import rbu_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rbu_cmd_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               do_push, do_pop;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(DEPTH))
		else $error("command queue over depth");

endmodule

// ===== src/rbu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbu_back
// Offset stage: places each command at the running destination offset and
// holds the finished request in the output register.
// ----------------------------------------------------------------------------
module rbu_back #(
	parameter int unsigned OFFSET_BITS = rbu_pkg::OFFSET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	input  rbu_pkg::rbu_cmd_t cmd,
	output logic              cmd_pop,
	output logic              empty,
	input  logic              pop,
	output rbu_pkg::rbu_out_t out_item
);
	import rbu_pkg::*;

	logic [OFFSET_BITS-1:0] offset_q, base;
	logic                   out_valid_q;
	rbu_out_t               out_q;

	assign empty    = !out_valid_q;
	assign out_item = out_q;
	assign cmd_pop  = !cmd_empty && (!out_valid_q || pop);
	assign base     = cmd.restart ? '0 : offset_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			out_q.fill_value  <= cmd.value;
			out_q.fill_length <= cmd.length;
			out_q.dest_offset <= DEST_OFFSET_W'(base);
			out_q.image_done  <= cmd.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			offset_q    <= '0;
		end else begin
			if (cmd_pop) begin
				out_valid_q <= 1'b1;
				offset_q    <= base + OFFSET_BITS'(cmd.length);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_len_vs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.fill_length == '0) == out_q.image_done))
		else $error("zero length request without end of image");

endmodule

// ===== src/rle_bitmap_unpacker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_bitmap_unpacker
// Run-length decoder that turns a packed bitmap byte stream into write
// requests (value, length, destination offset) for a bitmap writer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present one packed byte on in_data with push high; it is
//   taken at a rising edge where push is high and full is low. Set
//   in_data.image_start on the first byte of each image; it clears the
//   parser and restarts the destination offset at zero.
//   Output channel: while empty is low, out_data holds the oldest write
//   request; it is taken at a rising edge where pop is high.
//   Each byte yields zero or one request. Zero-length runs, copies and skips
//   yield nothing. The end-of-image long code yields one request with
//   fill_length 0 and image_done set; bytes after it are dropped until the
//   next image start.
//   Throughput: one byte per cycle, sustained, as long as pop keeps up.
//   Path: a byte's request goes from the parser into the command queue,
//   then the offset stage moves it into the output register.
//   Stalls: when pop stays low the output register holds, the command queue
//   (four entries) fills, and full rises; bytes that emit nothing are also
//   held back while full is high.
//   Reset (arst_n low) empties the queue and the output register, puts the
//   parser at the opcode phase and the offset at zero.
// ----------------------------------------------------------------------------
module rle_bitmap_unpacker #(
	parameter int unsigned OFFSET_BITS = rbu_pkg::OFFSET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  rbu_pkg::rbu_in_t  in_data,
	output logic              empty,
	input  logic              pop,
	output rbu_pkg::rbu_out_t out_data
);
	import rbu_pkg::*;

	logic     accept;
	logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
	rbu_cmd_t cmd_wr, cmd_rd;

	// full reflects the queue alone, so a byte is never half-taken
	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// front: byte parser, classifies opcodes and builds write commands
	rbu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_item  (in_data),
		.cmd_push (cmd_push),
		.cmd      (cmd_wr)
	);

	// decoupling queue between the parser and the offset stage
	rbu_cmd_fifo #(
		.DEPTH (CMD_FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wr_cmd (cmd_wr),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rd_cmd (cmd_rd),
		.empty  (cmd_empty)
	);

	// back: running destination offset and the output register
	rbu_back #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_rd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_data)
	);

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rle_bitmap_unpacker: packed images go in, write
// requests are predicted in order and compared on every field.
// ----------------------------------------------------------------------------
module tb;
	import rbu_pkg::*;

	localparam int unsigned OFFSET_BITS   = OFFSET_BITS_DEF;
	localparam int unsigned IDLE_LIMIT    = 5000;  // cycles with no request moving
	localparam int unsigned DRAIN_CYCLES  = 12;    // pipeline is two deep, plus margin
	localparam int unsigned HOLD_CYCLES   = 400;   // long receiver hold-off
	localparam int unsigned STREAM_TARGET = 2000;  // total packed bytes incl. the wrap image

	// Parser phases of the prediction
	typedef enum logic [3:0] {
		ST_OPCODE,
		ST_RUN_COUNT,
		ST_RUN_VALUE,
		ST_COPY,
		ST_LONG_LO,
		ST_LONG_HI,
		ST_LONG_VALUE,
		ST_DONE
	} parse_st_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      pop = 1'b0;
	logic      full;
	logic      empty;
	rbu_in_t   in_data = '0;
	rbu_out_t  out_data;

	rle_bitmap_unpacker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_data  (in_data),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Byte-stream decoder prediction
	// ------------------------------------------------------------------------
	parse_st_t            parse_st = ST_OPCODE;
	logic [14:0]          pend_len = '0;     // run length or literals left
	logic [7:0]           long_lo = '0;      // low byte of a long code
	logic [63:0]          wr_offset = '0;    // next destination offset
	rbu_out_t             pending_writes[$]; // predicted write requests, oldest first
	int unsigned          offset_wraps = 0;

	// Queue one write request and move the destination offset past it
	task automatic emit_write(input logic [7:0] value, input logic [14:0] len,
			input logic done);
		rbu_out_t w;
		logic [63:0] nxt;
		w.fill_value  = value;
		w.fill_length = len;
		w.dest_offset = wr_offset[DEST_OFFSET_W-1:0];
		w.image_done  = done;
		pending_writes.push_back(w);
		nxt = wr_offset + 64'(len);
		if (nxt >= (64'd1 << OFFSET_BITS))
			offset_wraps++;
		wr_offset = nxt & ((64'd1 << OFFSET_BITS) - 1);
	endtask

	task automatic decode_byte(input rbu_in_t it);
		logic [7:0]  b;
		logic [15:0] code;
		b = it.src_byte;
		// image start clears everything, then the byte is an opcode
		if (it.image_start) begin
			parse_st  = ST_OPCODE;
			pend_len  = '0;
			long_lo   = '0;
			wr_offset = '0;
		end
		case (parse_st)
			ST_OPCODE: begin
				if (b == OP_RUN) begin
					parse_st = ST_RUN_COUNT;
				end else if (b < OP_LONG) begin
					pend_len = 15'(b);
					parse_st = ST_COPY;
				end else if (b > OP_LONG) begin
					emit_write(8'h00, 15'(b & OP_SKIP_MASK), 1'b0);
				end else begin
					parse_st = ST_LONG_LO;
				end
			end
			ST_RUN_COUNT: begin
				pend_len = 15'(b);
				parse_st = ST_RUN_VALUE;
			end
			ST_RUN_VALUE, ST_LONG_VALUE: begin
				// value byte is eaten even for a zero-length run
				parse_st = ST_OPCODE;
				if (pend_len != 0)
					emit_write(b, pend_len, 1'b0);
			end
			ST_COPY: begin
				if (pend_len != 0)
					pend_len = pend_len - 15'd1;
				if (pend_len == 0)
					parse_st = ST_OPCODE;
				emit_write(b, 15'd1, 1'b0);
			end
			ST_LONG_LO: begin
				long_lo  = b;
				parse_st = ST_LONG_HI;
			end
			ST_LONG_HI: begin
				code     = {b, long_lo};
				parse_st = ST_OPCODE;
				if (code == LONG_END) begin
					parse_st = ST_DONE;
					emit_write(8'h00, 15'd0, 1'b1);
				end else if (code < LONG_COPY_MIN) begin
					emit_write(8'h00, 15'(code), 1'b0);
				end else if (code < LONG_RUN_MIN) begin
					pend_len = 15'(code & LONG_COPY_MSK);
					if (pend_len != 0)
						parse_st = ST_COPY;
				end else begin
					pend_len = 15'(code & LONG_RUN_MSK);
					parse_st = ST_LONG_VALUE;
				end
			end
			default: ;  // after image end: dropped until next start
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Stream builder
	// ------------------------------------------------------------------------
	rbu_in_t     packed_stream[$];  // bytes waiting to be pushed
	logic        start_pending = 1'b0;
	int unsigned stream_bytes = 0;

	// The first byte after start_pending is raised carries image_start
	task automatic add_byte(input logic [7:0] b);
		rbu_in_t it;
		it.src_byte    = b;
		it.image_start = start_pending;
		start_pending  = 1'b0;
		packed_stream.push_back(it);
		stream_bytes++;
	endtask

	task automatic add_long(input logic [15:0] code);
		add_byte(OP_LONG);
		add_byte(code[7:0]);
		add_byte(code[15:8]);
	endtask

	task automatic add_command();
		int unsigned kind;
		int unsigned n;
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			// short run, sometimes zero length
			add_byte(OP_RUN);
			add_byte(($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom));
			add_byte(8'($urandom));
		end else if (kind < 35) begin
			// short copy; mostly a few literals, now and then up to 127
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 127)
			                                 : $urandom_range(1, 6);
			add_byte(8'(n));
			repeat (n) add_byte(8'($urandom));
		end else if (kind < 50) begin
			add_byte(8'($urandom_range(129, 255)));
		end else if (kind < 60) begin
			add_long(16'($urandom_range(1, 32767)));
		end else if (kind < 75) begin
			// long copy, including the empty one
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
			                                : $urandom_range(0, 5);
			add_long(LONG_COPY_MIN | 16'(n));
			repeat (n) add_byte(8'($urandom));
		end else begin
			n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16383);
			add_long(LONG_RUN_MIN | 16'(n));
			add_byte(8'($urandom));
		end
	endtask

	task automatic add_image();
		start_pending = 1'b1;
		if ($urandom_range(0, 9) == 0) begin
			// noise: random bytes, stray image starts cut commands short
			repeat ($urandom_range(1, 30)) begin
				if ($urandom_range(0, 15) == 0)
					start_pending = 1'b1;
				add_byte(8'($urandom));
			end
		end else begin
			repeat ($urandom_range(1, 16)) add_command();
			if ($urandom_range(0, 7) != 0) begin
				add_long(LONG_END);
				// trailing bytes must be dropped
				repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: bursts of random length with random gaps. A request that
	// meets full stays on the bus unchanged until it is taken.
	// ------------------------------------------------------------------------
	int unsigned burst_left = 16;
	int unsigned gap_left = 0;
	int unsigned bytes_taken = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				decode_byte(in_data);
				void'(packed_stream.pop_front());
				bytes_taken++;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 48);
					// a third of the bursts run straight on with no gap
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			if (!(push && full)) begin
				if (gap_left != 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (packed_stream.size() != 0) begin
					push    <= 1'b1;
					in_data <= packed_stream[0];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor and checker
	// ------------------------------------------------------------------------
	int unsigned errors = 0;
	int unsigned writes_seen = 0;
	int unsigned images_done = 0;

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		errors++;
		if (errors <= 40)
			$display("%0t: write request %0d, %s: got 0x%0h, expected 0x%0h",
				$time, writes_seen, what, got, want);
	endtask

	task automatic check_write(input rbu_out_t got);
		rbu_out_t want;
		writes_seen++;
		if (pending_writes.size() == 0) begin
			report_mismatch("request with none expected, dest_offset",
				got.dest_offset, 0);
		end else begin
			want = pending_writes.pop_front();
			if (got.fill_value !== want.fill_value)
				report_mismatch("fill_value", got.fill_value, want.fill_value);
			if (got.fill_length !== want.fill_length)
				report_mismatch("fill_length", got.fill_length, want.fill_length);
			if (got.dest_offset !== want.dest_offset)
				report_mismatch("dest_offset", got.dest_offset, want.dest_offset);
			if (got.image_done !== want.image_done)
				report_mismatch("image_done", got.image_done, want.image_done);
			if (want.image_done)
				images_done++;
		end
	endtask

	// Receiver stall modes: pop always, a fixed pattern from stall_pat, or coin
	// flips. Mode and pattern are redrawn when mode_cycles wraps. On top of that, two
	// long hold-offs let the block fill up and raise full.
	logic        draining = 1'b0;
	logic [1:0]  rx_mode = 2'd0;
	logic [15:0] stall_pat = 16'hffff;
	int unsigned mode_cycles = 0;
	int unsigned hold_left = 0;
	logic        pop_nxt;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				check_write(out_data);
				if (writes_seen == 200 || writes_seen == 500)
					hold_left = HOLD_CYCLES;
			end
			mode_cycles++;
			if (mode_cycles == 64) begin
				mode_cycles = 0;
				rx_mode     = 2'($urandom_range(0, 2));
				stall_pat   = 16'($urandom);
			end
			if (draining) begin
				pop_nxt = 1'b1;
			end else if (hold_left != 0) begin
				hold_left--;
				pop_nxt = 1'b0;
			end else begin
				case (rx_mode)
					2'd0:    pop_nxt = 1'b1;
					2'd1:    pop_nxt = stall_pat[mode_cycles[3:0]];
					default: pop_nxt = 1'($urandom_range(0, 1));
				endcase
			end
			pop <= pop_nxt;
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: ends a run that stops moving requests on either side
	// ------------------------------------------------------------------------
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		logic wrap_added;
		wrap_added = 1'b0;

		// Directed image: extremes of every command form
		start_pending = 1'b1;
		add_byte(OP_RUN);               // run of 255 x 0xff
		add_byte(8'hff);
		add_byte(8'hff);
		add_byte(OP_RUN);               // zero-length run, value still eaten
		add_byte(8'h00);
		add_byte(8'hab);
		add_byte(8'hff);                // largest short skip
		add_byte(8'h01);                // one literal
		add_byte(8'h00);
		add_long(16'h7fff);             // largest long skip
		add_long(LONG_COPY_MIN);        // empty long copy, next byte is an opcode
		add_long(LONG_COPY_MIN | 16'h0001);
		add_byte(8'h5a);
		add_long(16'hffff);             // largest long run
		add_byte(8'h77);
		add_long(LONG_END);
		add_byte(8'h42);                // ignored after the end
		start_pending = 1'b1;
		add_byte(8'h83);                // new image, offset back at zero

		// Random images; one of them pushes the offset past its wrap point
		while (stream_bytes < STREAM_TARGET) begin
			add_image();
			if (!wrap_added && stream_bytes > 250) begin
				wrap_added    = 1'b1;
				start_pending = 1'b1;
				repeat (513) add_long(16'h7fff);
				add_byte(8'h85);
				add_long(LONG_END);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (packed_stream.size() != 0 || pending_writes.size() != 0)
			@(negedge clk);
		// let bytes that produce nothing clear, and catch stray requests
		draining = 1'b1;
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d packed bytes, %0d write requests, %0d image ends",
			bytes_taken, writes_seen, images_done);
		$display("offset wrapped %0d times; %0d mismatches", offset_wraps, errors);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== rle_bitmap_unpacker.f =====
src/rbu_pkg.sv
src/rbu_front.sv
src/rbu_cmd_fifo.sv
src/rbu_back.sv
src/rle_bitmap_unpacker.sv
test/tb.sv
